// ===== hw/rtl/bsmd_pkg.sv =====
package bsmd_pkg;

    // Bus access kinds carried in the command field.
    typedef enum logic [1:0] {
        CMD_READ   = 2'd0,
        CMD_FETCH  = 2'd1,
        CMD_WRITE  = 2'd2,
        CMD_PORT_F = 2'd3
    } cmd_t;

    // Configuration register indexes.
    localparam logic [1:0] CFG_CARD_8K  = 2'd0;
    localparam logic [1:0] CFG_CARD_16K = 2'd1;
    localparam logic [1:0] CFG_CARD_32K = 2'd2;

    // Address map constants.
    localparam logic [15:0] UPPER_BASE   = 16'h8000;
    localparam logic [16:0] UPPER_SHIFT  = 17'h08000;
    localparam logic [16:0] CARD_SHIFT   = 17'h02000;
    localparam logic [15:0] LCD_BASE     = 16'h7000;
    localparam logic [7:0]  LCD_WIN_LAST = 8'h7C;
    localparam int unsigned BANK_SEL_BIT = 1;

    // Upper address bytes of the single-page control targets.
    localparam logic [7:0] PAGE_BANK     = 8'h71;
    localparam logic [7:0] PAGE_CAPS     = 8'h77;
    localparam logic [7:0] PAGE_STROBE_L = 8'h7A;
    localparam logic [7:0] PAGE_STROBE_H = 8'h7B;

    typedef struct packed {
        logic card_8k;
        logic card_16k;
        logic card_32k;
    } cfg_t;

    typedef struct packed {
        logic [7:0] bank;
        logic       protect;
        logic       caps;
        logic [7:0] strobe;
    } state_t;

    // Result beat, last field in the lowest bits.
    typedef struct packed {
        logic        caps_lock;
        logic [7:0]  key_strobe;
        logic [11:0] lcd_offset;
        logic        lcd_dirty;
        logic [16:0] mapped_address;
        logic        allowed;
    } result_t;

endpackage

// ===== hw/rtl/bsmd_decode.sv =====
module bsmd_decode
    import bsmd_pkg::*;
(
    input  cmd_t        command,
    input  logic [15:0] address,
    input  logic [7:0]  write_data,
    input  logic [7:0]  old_byte,
    input  cfg_t        cfg,
    input  state_t      state,
    output state_t      state_next,
    output result_t     result
);

    logic [7:0]  page;
    logic        in_lcd;
    logic        bank_sel;
    logic        card_low_hit;
    logic [16:0] addr_ext;
    logic [16:0] ram_addr;
    logic        ram_allowed;
    logic [15:0] lcd_diff;

    assign page     = address[15:8];
    assign bank_sel = state.bank[BANK_SEL_BIT];
    assign addr_ext = {1'b0, address};
    assign lcd_diff = address - LCD_BASE;

    // The 8K card window covers 0x2000-0x3FFF.
    assign card_low_hit = (address[15:13] == 3'b001) && cfg.card_8k;

    // LCD windows sit on even pages 0x70 through 0x78, low byte up to 0x7C.
    always_comb begin
        in_lcd = 1'b0;
        case (page)
            8'h70, 8'h72, 8'h74, 8'h76, 8'h78: in_lcd = (address[7:0] <= LCD_WIN_LAST);
            default:                           in_lcd = 1'b0;
        endcase
    end

    // RAM write target after the card shift and its card gating.
    always_comb begin
        ram_addr = card_low_hit ? (addr_ext + CARD_SHIFT) : addr_ext;
        case (ram_addr[16:13])
            4'b0001: ram_allowed = cfg.card_16k | cfg.card_32k;
            4'b0010: ram_allowed = cfg.card_8k | cfg.card_16k | cfg.card_32k;
            4'b0011: ram_allowed = 1'b1;
            default: ram_allowed = 1'b0;
        endcase
    end

    // Access decode and state update.
    always_comb begin
        state_next            = state;
        result.allowed        = 1'b0;
        result.mapped_address = addr_ext;
        result.lcd_dirty      = 1'b0;
        result.lcd_offset     = '0;
        case (command)
            CMD_READ: begin
                result.allowed = 1'b1;
                if (address[15:13] == 3'b000) begin
                    result.mapped_address = addr_ext;
                end else if (card_low_hit) begin
                    result.mapped_address = addr_ext + CARD_SHIFT;
                end else if ((address >= UPPER_BASE) && (bank_sel || state.protect)) begin
                    result.mapped_address = addr_ext + UPPER_SHIFT;
                end
            end
            CMD_FETCH: begin
                result.allowed = 1'b1;
                if ((address >= UPPER_BASE) && bank_sel) begin
                    result.mapped_address = addr_ext + UPPER_SHIFT;
                end
            end
            CMD_WRITE: begin
                if (page == PAGE_BANK) begin
                    state_next.bank = write_data;
                    result.allowed  = 1'b1;
                end else if (page == PAGE_CAPS) begin
                    state_next.caps = (write_data != 8'h00);
                    result.allowed  = 1'b1;
                end else if (in_lcd) begin
                    if (old_byte != write_data) begin
                        result.lcd_dirty  = 1'b1;
                        result.lcd_offset = lcd_diff[11:0];
                    end
                    result.allowed = 1'b1;
                end else if (page == PAGE_STROBE_L) begin
                    state_next.strobe[3:0] = write_data[3:0];
                    result.allowed         = 1'b1;
                end else if (page == PAGE_STROBE_H) begin
                    state_next.strobe[7:4] = write_data[3:0];
                    result.allowed         = 1'b1;
                end else begin
                    result.mapped_address = ram_addr;
                    result.allowed        = ram_allowed;
                end
            end
            CMD_PORT_F: begin
                state_next.protect    = write_data[0];
                result.mapped_address = '0;
            end
            default: begin
                result.mapped_address = addr_ext;
            end
        endcase
        result.key_strobe = state_next.strobe;
        result.caps_lock  = state_next.caps;
    end

endmodule

// ===== hw/rtl/bank_switched_memory_map_decoder_top.sv =====
// A result beat appears on the master side in the cycle after its access is accepted.
// Throughput: one access per cycle while m_tready is held high; the decode sits between the slave port and the result
// register, and the next access is taken in the same cycle the waiting result is drained.
// Reset (aresetn low, synchronous) clears the card settings, bank register, protect flag,
// caps flag, key strobe and the result valid flag.
module bank_switched_memory_map_decoder_top
    import bsmd_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    // Configuration write port.
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_index,
    input  logic [0:0]  cfg_wdata,
    // Access beats.
    input  logic        s_tvalid,
    output logic        s_tready,
    // s_tdata: command[1:0], address[17:2], write_data[25:18], old_byte[33:26], zero pad.
    input  logic [39:0] s_tdata,
    // Result beats.
    output logic        m_tvalid,
    input  logic        m_tready,
    // m_tdata: allowed[0], mapped_address[17:1], lcd_dirty[18], lcd_offset[30:19],
    // key_strobe[38:31], caps_lock[39].
    output logic [39:0] m_tdata
);

    cfg_t    cfg_reg;
    state_t  state_reg;
    state_t  state_next;
    result_t result_next;
    result_t result_reg;
    logic    m_tvalid_reg;
    logic    s_accept;
    cmd_t    s_command;

    assign s_tready  = !m_tvalid_reg || m_tready;
    assign s_accept  = s_tvalid && s_tready;
    assign s_command = cmd_t'(s_tdata[1:0]);
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = result_reg;

    // Card configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '0;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                CFG_CARD_8K:  cfg_reg.card_8k  <= cfg_wdata[0];
                CFG_CARD_16K: cfg_reg.card_16k <= cfg_wdata[0];
                CFG_CARD_32K: cfg_reg.card_32k <= cfg_wdata[0];
                default:      cfg_reg <= cfg_reg;
            endcase
        end
    end

    bsmd_decode u_decode (
        .command    (s_command),
        .address    (s_tdata[17:2]),
        .write_data (s_tdata[25:18]),
        .old_byte   (s_tdata[33:26]),
        .cfg        (cfg_reg),
        .state      (state_reg),
        .state_next (state_next),
        .result     (result_next)
    );

    // Machine state advances on every accepted beat.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= '0;
        end else if (s_accept) begin
            state_reg <= state_next;
        end
    end

    // Result register with its valid flag.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (s_accept) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            result_reg <= result_next;
        end
    end

`ifndef SYNTHESIS
    // A port F write never reaches memory.
    a_port_f_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_accept && s_command == CMD_PORT_F) |=>
            (!result_reg.allowed && result_reg.mapped_address == '0))
        else $error("port F write produced a memory access");

    // Reads and fetches are always allowed.
    a_read_allowed: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_accept && (s_command == CMD_READ || s_command == CMD_FETCH)) |=>
            result_reg.allowed)
        else $error("read or fetch refused");

    // A dirty LCD byte implies an allowed write.
    a_dirty_allowed: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && result_reg.lcd_dirty) |-> result_reg.allowed)
        else $error("dirty LCD flag on a refused access");

    // Machine state only moves when a beat is taken.
    a_state_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (!s_accept) |=> $stable(state_reg))
        else $error("state changed without an accepted beat");
`endif

endmodule

// ===== test/tb.sv =====
module tb
    import bsmd_pkg::*;
;

    timeunit 1ns;
    timeprecision 1ps;

    // One bus access as it travels on the slave side.
    typedef struct {
        cmd_t       cmd;
        logic [15:0] addr;
        logic [7:0]  wdata;
        logic [7:0]  old;
    } access_t;

    localparam int NUM_SETTINGS    = 8;
    localparam int RANDOM_PER_STEP = 125;
    localparam int IDLE_PERCENT    = 38;

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic [1:0]  cfg_index = CFG_CARD_8K;
    logic [0:0]  cfg_wdata = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [39:0] s_tdata   = '0;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [39:0] m_tdata;

    // Card settings and decoder state as the predictor sees them.
    logic        card8_fitted  = 1'b0;
    logic        card16_fitted = 1'b0;
    logic        card32_fitted = 1'b0;
    logic [7:0]  bank_latch    = '0;
    logic        protect_latch = 1'b0;
    logic        caps_latch    = 1'b0;
    logic [7:0]  strobe_latch  = '0;

    access_t     pending_accesses[$];
    result_t     decode_expected[$];
    access_t     beat_on_bus;
    result_t     predicted;
    result_t     observed;
    result_t     wanted;
    logic        steady = 1'b0;

    int          accesses_sent   = 0;
    int          results_checked = 0;
    int          mismatches      = 0;
    int          per_cmd[4]      = '{0, 0, 0, 0};
    int          dirty_writes    = 0;
    int          refused_writes  = 0;

    bank_switched_memory_map_decoder_top uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    // Free-running 50 MHz clock.
    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // Decodes one access against the current card settings and updates the latches.
    function automatic result_t decode_access(input access_t a);
        result_t     r;
        logic [16:0] phys;
        logic [7:0]  page;
        logic        in_lcd;
        r      = '0;
        phys   = {1'b0, a.addr};
        page   = a.addr[15:8];
        in_lcd = (page >= 8'h70) && (page <= 8'h78) && !page[0]
                 && (a.addr[7:0] <= LCD_WIN_LAST);
        case (a.cmd)
            CMD_READ: begin
                r.allowed = 1'b1;
                if (a.addr >= 16'h2000 && a.addr <= 16'h3FFF && card8_fitted) begin
                    phys = phys + CARD_SHIFT;
                end else if (a.addr >= UPPER_BASE
                             && (bank_latch[BANK_SEL_BIT] || protect_latch)) begin
                    phys = phys + UPPER_SHIFT;
                end
                r.mapped_address = phys;
            end
            CMD_FETCH: begin
                r.allowed = 1'b1;
                if (a.addr >= UPPER_BASE && bank_latch[BANK_SEL_BIT]) begin
                    phys = phys + UPPER_SHIFT;
                end
                r.mapped_address = phys;
            end
            CMD_WRITE: begin
                if (page == PAGE_BANK) begin
                    bank_latch = a.wdata;
                    r.allowed  = 1'b1;
                end else if (page == PAGE_CAPS) begin
                    caps_latch = (a.wdata != 8'h00);
                    r.allowed  = 1'b1;
                end else if (in_lcd) begin
                    if (a.old != a.wdata) begin
                        r.lcd_dirty  = 1'b1;
                        r.lcd_offset = 12'(a.addr - LCD_BASE);
                    end
                    r.allowed = 1'b1;
                end else if (page == PAGE_STROBE_L) begin
                    strobe_latch[3:0] = a.wdata[3:0];
                    r.allowed         = 1'b1;
                end else if (page == PAGE_STROBE_H) begin
                    strobe_latch[7:4] = a.wdata[3:0];
                    r.allowed         = 1'b1;
                end else begin
                    // Plain RAM write: the 8K card moves its window up first.
                    if (phys >= 17'h02000 && phys <= 17'h03FFF && card8_fitted) begin
                        phys = phys + CARD_SHIFT;
                    end
                    if (phys >= 17'h02000 && phys <= 17'h03FFF) begin
                        r.allowed = card16_fitted | card32_fitted;
                    end else if (phys >= 17'h04000 && phys <= 17'h05FFF) begin
                        r.allowed = card8_fitted | card16_fitted | card32_fitted;
                    end else if (phys >= 17'h06000 && phys <= 17'h07FFF) begin
                        r.allowed = 1'b1;
                    end
                end
                if (page != PAGE_BANK && page != PAGE_CAPS && !in_lcd
                    && page != PAGE_STROBE_L && page != PAGE_STROBE_H) begin
                    r.mapped_address = phys;
                end else begin
                    r.mapped_address = {1'b0, a.addr};
                end
            end
            default: begin
                // Port F write loads the protect flag and reaches no memory.
                protect_latch = a.wdata[0];
            end
        endcase
        r.key_strobe = strobe_latch;
        r.caps_lock  = caps_latch;
        return r;
    endfunction

    // Random access, weighted toward the decoded control pages and RAM areas.
    function automatic access_t random_access();
        access_t a;
        int      pick;
        pick    = $urandom_range(99);
        a.cmd   = (pick < 25) ? CMD_READ : (pick < 45) ? CMD_FETCH :
                  (pick < 87) ? CMD_WRITE : CMD_PORT_F;
        a.wdata = 8'($urandom_range(255));
        a.old   = 8'($urandom_range(255));
        case ($urandom_range(9))
            0, 1: a.addr = 16'($urandom_range(16'hFFFF));
            2: begin
                case ($urandom_range(3))
                    0: a.addr[15:8] = PAGE_BANK;
                    1: a.addr[15:8] = PAGE_CAPS;
                    2: a.addr[15:8] = PAGE_STROBE_L;
                    default: a.addr[15:8] = PAGE_STROBE_H;
                endcase
                a.addr[7:0] = 8'($urandom_range(255));
            end
            3, 4: begin
                a.addr[15:8] = 8'(8'h70 + 2 * $urandom_range(4));
                a.addr[7:0]  = $urandom_range(3) == 0 ? 8'($urandom_range(8'h7F, 8'h7A))
                                                      : 8'($urandom_range(LCD_WIN_LAST));
                if ($urandom_range(1)) a.old = a.wdata;
            end
            5, 6: a.addr = 16'($urandom_range(16'h7FFF, 16'h2000));
            7: a.addr = 16'($urandom_range(16'hFFFF, 16'h8000));
            8: a.addr = 16'($urandom_range(16'h1FFF));
            default: a.addr = 16'($urandom_range(16'h3FFF, 16'h2000));
        endcase
        return a;
    endfunction

    task automatic queue_access(input cmd_t c, input logic [15:0] ad,
                                input logic [7:0] wd, input logic [7:0] od);
        access_t a;
        a.cmd   = c;
        a.addr  = ad;
        a.wdata = wd;
        a.old   = od;
        pending_accesses.push_back(a);
    endtask

    // Writes all three card registers in turn; the block is idle here.
    task automatic set_cards(input logic c8, input logic c16, input logic c32);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= CFG_CARD_8K;
        cfg_wdata <= c8;
        @(posedge aclk);
        cfg_index <= CFG_CARD_16K;
        cfg_wdata <= c16;
        @(posedge aclk);
        cfg_index <= CFG_CARD_32K;
        cfg_wdata <= c32;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        card8_fitted  = c8;
        card16_fitted = c16;
        card32_fitted = c32;
    endtask

    task automatic wait_drained();
        while (pending_accesses.size() != 0 || s_tvalid || decode_expected.size() != 0)
            @(posedge aclk);
    endtask

    // Driver: predicts each accepted access, then offers the next one or idles.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                predicted = decode_access(beat_on_bus);
                decode_expected.push_back(predicted);
                accesses_sent++;
                per_cmd[beat_on_bus.cmd]++;
                if (predicted.lcd_dirty) dirty_writes++;
                if (beat_on_bus.cmd == CMD_WRITE && !predicted.allowed) refused_writes++;
            end
            if (!s_tvalid || s_tready) begin
                if (pending_accesses.size() != 0
                    && (steady || $urandom_range(99) >= IDLE_PERCENT)) begin
                    beat_on_bus = pending_accesses.pop_front();
                    s_tdata  <= {6'b0, beat_on_bus.old, beat_on_bus.wdata,
                                 beat_on_bus.addr, beat_on_bus.cmd};
                    s_tvalid <= 1'b1;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Monitor: checks every result beat against the oldest prediction.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                observed = result_t'(m_tdata);
                if (decode_expected.size() == 0) begin
                    mismatches++;
                    $display("%0t: unexpected result beat, expected none, got %h",
                             $time, m_tdata);
                end else begin
                    wanted = decode_expected.pop_front();
                    results_checked++;
                    if (observed !== wanted) begin
                        mismatches++;
                        $display("%0t: result %0d mismatch: expected %h, actual %h",
                                 $time, results_checked, wanted, observed);
                    end
                end
            end
            m_tready <= steady || ($urandom_range(99) >= IDLE_PERCENT);
        end
    end

    // Stimulus: one phase per card setting, with directed accesses at the start of the first phase.
    initial begin
        logic [2:0] settings[NUM_SETTINGS];
        settings = '{3'b000, 3'b001, 3'b010, 3'b100, 3'b111, 3'b011, 3'b101, 3'b110};
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        for (int p = 0; p < NUM_SETTINGS; p++) begin
            set_cards(settings[p][0], settings[p][1], settings[p][2]);
            steady = (p == 3);
            if (p == 0) begin
                queue_access(CMD_READ,   16'h0000, 8'h00, 8'h00);
                queue_access(CMD_READ,   16'hFFFF, 8'hFF, 8'hFF);
                queue_access(CMD_READ,   16'h1FFF, 8'h00, 8'h00);
                queue_access(CMD_FETCH,  16'h8000, 8'h00, 8'h00);
                queue_access(CMD_FETCH,  16'h7FFF, 8'h00, 8'h00);
                // Select the second ROM bank, then read and fetch the upper half.
                queue_access(CMD_WRITE,  16'h7100, 8'h02, 8'h00);
                queue_access(CMD_FETCH,  16'hFFFF, 8'h00, 8'h00);
                queue_access(CMD_READ,   16'h8000, 8'h00, 8'h00);
                queue_access(CMD_WRITE,  16'h71FF, 8'hFD, 8'h00);
                // Protect flag remaps data reads but not fetches.
                queue_access(CMD_PORT_F, 16'hFFFF, 8'h01, 8'hFF);
                queue_access(CMD_READ,   16'h8000, 8'h00, 8'h00);
                queue_access(CMD_FETCH,  16'h8000, 8'h00, 8'h00);
                queue_access(CMD_PORT_F, 16'h0000, 8'hFE, 8'h00);
                queue_access(CMD_WRITE,  16'h7700, 8'h80, 8'h00);
                queue_access(CMD_WRITE,  16'h77FF, 8'h00, 8'h00);
                // LCD windows: changed byte, unchanged byte, one past the window.
                queue_access(CMD_WRITE,  16'h7000, 8'h55, 8'hAA);
                queue_access(CMD_WRITE,  16'h787C, 8'h3C, 8'h3C);
                queue_access(CMD_WRITE,  16'h727C, 8'hFF, 8'h00);
                queue_access(CMD_WRITE,  16'h787D, 8'h12, 8'h34);
                // Key strobe nibbles take only the low nibble of the data.
                queue_access(CMD_WRITE,  16'h7A00, 8'hFF, 8'h00);
                queue_access(CMD_WRITE,  16'h7BFF, 8'hA5, 8'h00);
                // RAM gating without cards, and refused writes outside RAM.
                queue_access(CMD_WRITE,  16'h2000, 8'h11, 8'h00);
                queue_access(CMD_WRITE,  16'h5FFF, 8'h22, 8'h00);
                queue_access(CMD_WRITE,  16'h6000, 8'h33, 8'h00);
                queue_access(CMD_WRITE,  16'h8000, 8'h44, 8'h00);
                queue_access(CMD_WRITE,  16'h1FFF, 8'h55, 8'h00);
            end
            for (int i = 0; i < RANDOM_PER_STEP; i++)
                pending_accesses.push_back(random_access());
            wait_drained();
        end
        steady = 1'b0;
        repeat (4) @(posedge aclk);
        $display("Covered %0d card settings, %0d accesses: %0d rd, %0d fetch, %0d wr, %0d port F.",
                 NUM_SETTINGS, accesses_sent, per_cmd[CMD_READ], per_cmd[CMD_FETCH],
                 per_cmd[CMD_WRITE], per_cmd[CMD_PORT_F]);
        $display("Checked %0d results, including %0d dirty LCD writes and %0d refused writes.",
                 results_checked, dirty_writes, refused_writes);
        if (mismatches == 0 && decode_expected.size() == 0) begin
            $display("bank_switched_memory_map_decoder_top test passed");
        end else begin
            $display("bank_switched_memory_map_decoder_top test failed");
        end
        $finish;
    end

    // Watchdog against a hung handshake.
    initial begin
        #5ms;
        $display("%0t: timeout with %0d results still expected", $time, decode_expected.size());
        $display("bank_switched_memory_map_decoder_top test failed");
        $finish;
    end

endmodule

// ===== bank_switched_memory_map_decoder_top.f =====
hw/rtl/bsmd_pkg.sv
hw/rtl/bsmd_decode.sv
hw/rtl/bank_switched_memory_map_decoder_top.sv
test/tb.sv
